// ----- rtl/bcd_clock_sync_timestamp_core_defines.svh -----
// Assertion macros for the timestamp core RTL.
// Expects signals named clk and rst in the scope of use.
`ifndef BCD_CLOCK_SYNC_TIMESTAMP_CORE_DEFINES_SVH
`define BCD_CLOCK_SYNC_TIMESTAMP_CORE_DEFINES_SVH

// Same-cycle implication, ignored during reset.
`define BCST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored during reset.
`define BCST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/bcst_pkg.sv -----
// Shared types, constants and decode functions of the timestamp core.
// No dependencies.
package bcst_pkg;

  localparam int unsigned FREQ_W = 25;
  localparam int unsigned SECS_W = 32;
  localparam int unsigned OFFS_W = 48;
  localparam int unsigned TS_W   = 44;
  localparam logic [FREQ_W-1:0] FREQ_RESET = 25'd32768;

  localparam logic OP_SYNC  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic              op;
    logic              status;
    logic [SECS_W-1:0] secs;
  } sync_info_t;

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_UPD, ST_TS} back_state_t;

  function automatic logic [7:0] bcd_value(input logic [7:0] b);
    return 8'(8'({4'd0, b[7:4]}) * 8'd10) + 8'({4'd0, b[3:0]});
  endfunction

  // Day of a March-based year on which the month starts.
  function automatic logic [8:0] month_doy(input logic [7:0] m);
    logic [8:0] d;
    case (m)
      8'd1:    d = 9'd306;
      8'd2:    d = 9'd337;
      8'd3:    d = 9'd0;
      8'd4:    d = 9'd31;
      8'd5:    d = 9'd61;
      8'd6:    d = 9'd92;
      8'd7:    d = 9'd122;
      8'd8:    d = 9'd153;
      8'd9:    d = 9'd184;
      8'd10:   d = 9'd214;
      8'd11:   d = 9'd245;
      8'd12:   d = 9'd275;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ----- rtl/bcst_front.sv -----
// Front end: takes a word, decodes the BCD calendar to Unix seconds.
// Depends on bcst_pkg.
module bcst_front import bcst_pkg::*; #(
  parameter int unsigned TICK_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic                 op,
  input  logic [31:0]          tick_count,
  input  logic [7:0]           seconds_bcd,
  input  logic [7:0]           minutes_bcd,
  input  logic [7:0]           hours_bcd,
  input  logic [7:0]           day_bcd,
  input  logic [7:0]           month_bcd,
  input  logic [7:0]           year_bcd,
  input  logic                 q_full,
  output logic                 q_push,
  output logic [TICK_BITS-1:0] q_tick,
  output sync_info_t           q_info
);

  logic                 busy, phase;
  logic                 op_r;
  logic [TICK_BITS-1:0] tick_r;
  logic [7:0]           sec_r, min_r, hour_r, day_r, mon_r, year_r;
  logic [16:0]          days_r;
  logic [17:0]          hms_r;
  logic                 bad_r;

  logic [7:0]  sec_v, min_v, hour_v, day_v, mon_v, year_v;
  logic        early, era4, bad;
  logic [8:0]  yoe;
  logic [1:0]  yoe_c;
  logic [17:0] doe;
  logic [20:0] days_w;
  logic [17:0] hms;
  logic [31:0] secs;

  assign full = busy;

  always_comb begin
    sec_v  = bcd_value(sec_r);
    min_v  = bcd_value(min_r);
    hour_v = bcd_value(hour_r);
    day_v  = bcd_value(day_r);
    mon_v  = bcd_value(mon_r);
    year_v = bcd_value(year_r);
    bad    = (mon_v < 8'd1) || (mon_v > 8'd12);
    early  = (mon_v <= 8'd2);
    era4   = early && (year_v == 8'd0);
    yoe    = era4 ? 9'd399 : (9'(year_v) - 9'(early));
    if (yoe >= 9'd300) begin
      yoe_c = 2'd3;
    end else if (yoe >= 9'd200) begin
      yoe_c = 2'd2;
    end else if (yoe >= 9'd100) begin
      yoe_c = 2'd1;
    end else begin
      yoe_c = 2'd0;
    end
    doe    = 18'(18'(yoe) * 18'd365) + 18'(yoe[8:2]) - 18'(yoe_c) + 18'(month_doy(mon_v));
    // base of era 5 minus the epoch, less one for day-of-month counting from one
    days_w = 21'(doe) + 21'(day_v) + 21'd11016 - (era4 ? 21'd146097 : 21'd0);
    hms    = 18'(18'(hour_v) * 18'd3600) + 18'(18'(min_v) * 18'd60) + 18'(sec_v);
    secs   = 32'(34'(days_r) * 34'd86400 + 34'(hms_r));
  end

  assign q_push        = busy && phase && !q_full;
  assign q_tick        = tick_r;
  assign q_info.op     = op_r;
  assign q_info.status = bad_r;
  assign q_info.secs   = (bad_r || op_r == OP_QUERY) ? '0 : secs;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 1'b0;
    end else if (!busy) begin
      if (push) begin
        busy  <= 1'b1;
        phase <= 1'b0;
      end
    end else if (!phase) begin
      phase <= 1'b1;
    end else if (!q_full) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && push) begin
      op_r   <= op;
      tick_r <= tick_count[TICK_BITS-1:0];
      sec_r  <= seconds_bcd & 8'h7f;
      min_r  <= minutes_bcd & 8'h7f;
      hour_r <= hours_bcd & 8'h3f;
      day_r  <= day_bcd & 8'h3f;
      mon_r  <= month_bcd & 8'h1f;
      year_r <= year_bcd;
    end
    if (busy && !phase) begin
      days_r <= days_w[16:0];
      hms_r  <= hms;
      bad_r  <= (op_r == OP_SYNC) && bad;
    end
  end

endmodule

// ----- rtl/bcst_queue.sv -----
// Small register queue between front and back ends.
// No dependencies.
module bcst_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  output logic             q_full,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             q_empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wp, rp;
  logic [CW-1:0]    cnt;

  assign q_full  = (cnt == CW'(DEPTH));
  assign q_empty = (cnt == '0);
  assign rdata   = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + AW'(1);
      end
      if (rd) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + AW'(1);
      end
      if (wr && !rd) begin
        cnt <= cnt + CW'(1);
      end else if (rd && !wr) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp] <= wdata;
    end
  end

endmodule

// ----- rtl/bcst_back.sv -----
// Back end: bit-serial tick divide, offset update and result register.
// Depends on bcst_pkg and the assertion macro header.
`include "bcd_clock_sync_timestamp_core_defines.svh"
module bcst_back import bcst_pkg::*; #(
  parameter int unsigned TICK_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [FREQ_W-1:0]        freq,
  input  logic                     q_empty,
  output logic                     q_pop,
  input  logic [TICK_BITS-1:0]     q_tick,
  input  sync_info_t               q_info,
  output logic                     empty,
  input  logic                     pop,
  output logic [TS_W-1:0]          timestamp_ms,
  output logic [SECS_W-1:0]        unix_seconds,
  output logic signed [OFFS_W-1:0] offset_ms,
  output logic                     status
);

  localparam int unsigned DW = TICK_BITS + 10;
  localparam int unsigned CW = $clog2(DW + 1);

  back_state_t state, state_next;
  sync_info_t  info;
  logic [DW-1:0]             dq;
  logic [FREQ_W-1:0]         rem, div_f;
  logic [CW-1:0]             cnt;
  logic signed [OFFS_W-1:0]  offset;
  logic                      out_valid;
  logic                      load_out;

  logic [FREQ_W:0]    trial;
  logic               qbit;
  logic signed [48:0] ts_sum;

  always_comb begin
    trial  = {rem, dq[DW-1]};
    qbit   = (trial >= {1'b0, div_f});
    ts_sum = $signed({{(49 - DW){1'b0}}, dq}) + $signed({offset[OFFS_W-1], offset});
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (!q_empty) state_next = ST_DIV;
      ST_DIV:  if (cnt == CW'(1)) state_next = ST_UPD;
      ST_UPD:  state_next = ST_TS;
      ST_TS:   if (!out_valid || pop) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    load_out = 1'b0;
    case (state)
      ST_IDLE: q_pop = !q_empty;
      ST_TS:   load_out = !out_valid || pop;
      default: begin
        q_pop    = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      offset    <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_UPD && info.op == OP_SYNC && !info.status) begin
        offset <= 48'(42'(info.secs) * 42'd1000) - 48'(dq);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      info  <= q_info;
      dq    <= DW'({q_tick, 10'd0}) - DW'({q_tick, 4'd0}) - DW'({q_tick, 3'd0});
      rem   <= '0;
      cnt   <= CW'(DW);
      div_f <= (freq == '0) ? FREQ_W'(1) : freq;
    end else if (state == ST_DIV) begin
      // shift the quotient bit in behind the dividend
      rem <= qbit ? FREQ_W'(trial - {1'b0, div_f}) : trial[FREQ_W-1:0];
      dq  <= {dq[DW-2:0], qbit};
      cnt <= cnt - CW'(1);
    end
    if (load_out) begin
      timestamp_ms <= ts_sum[48] ? '0 : ts_sum[TS_W-1:0];
      unix_seconds <= info.secs;
      offset_ms    <= offset;
      status       <= info.status;
    end
  end

  assign empty = !out_valid;

  `BCST_ASSERT_NEXT(a_div_ends, (state == ST_DIV && cnt == CW'(1)), (state == ST_UPD), "divide overran")
  `BCST_ASSERT_NOW(a_rem_below, (state == ST_DIV), (rem < div_f), "remainder not below divisor")
  `BCST_ASSERT_NOW(a_bad_no_secs, (out_valid && status), (unix_seconds == '0), "seconds on bad sync")

endmodule

// ----- rtl/bcd_clock_sync_timestamp_core.sv -----
// Top level of the BCD clock sync and timestamp core.
// Depends on bcst_pkg, bcst_front, bcst_queue and bcst_back.
//
//  channel  | direction | handshake         | words
//  ---------+-----------+-------------------+------------------------------------------
//  input    | in        | push / full       | op, tick_count, *_bcd calendar registers
//  result   | out       | empty / pop       | timestamp_ms, unix_seconds, offset_ms, status
//  config   | in        | cfg_we            | cfg_wdata = tick_frequency
//
// A word passes the front end in three steps (take, calendar decode, seconds
// multiply), then the back end's dequeue, divide, offset update and result load.
// The back end's one-bit-per-cycle divide of ticks*1000 by the frequency sets the
// pace; the front end decodes the next word meanwhile, with a two-entry queue between.
// Reset clears the offset to zero and the frequency to 32768.
// A waiting result holds the back end; words still enter until the queue is full.
module bcd_clock_sync_timestamp_core import bcst_pkg::*; #(
  parameter int unsigned TICK_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  logic                     op,
  input  logic [31:0]              tick_count,
  input  logic [7:0]               seconds_bcd,
  input  logic [7:0]               minutes_bcd,
  input  logic [7:0]               hours_bcd,
  input  logic [7:0]               day_bcd,
  input  logic [7:0]               month_bcd,
  input  logic [7:0]               year_bcd,
  output logic                     empty,
  input  logic                     pop,
  output logic [TS_W-1:0]          timestamp_ms,
  output logic [SECS_W-1:0]        unix_seconds,
  output logic signed [OFFS_W-1:0] offset_ms,
  output logic                     status,
  input  logic                     cfg_we,
  input  logic [FREQ_W-1:0]        cfg_wdata
);

  localparam int unsigned QW = TICK_BITS + $bits(sync_info_t);

  logic [FREQ_W-1:0]    freq;
  logic                 q_push, q_full, q_pop, q_empty;
  logic [TICK_BITS-1:0] f_tick, b_tick;
  sync_info_t           f_info, b_info;
  logic [QW-1:0]        q_rdata;

  // hold the tick frequency; the user must write it only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      freq <= FREQ_RESET;
    end else if (cfg_we) begin
      freq <= cfg_wdata;
    end
  end

  bcst_front #(.TICK_BITS(TICK_BITS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .op          (op),
    .tick_count  (tick_count),
    .seconds_bcd (seconds_bcd),
    .minutes_bcd (minutes_bcd),
    .hours_bcd   (hours_bcd),
    .day_bcd     (day_bcd),
    .month_bcd   (month_bcd),
    .year_bcd    (year_bcd),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_tick      (f_tick),
    .q_info      (f_info)
  );

  bcst_queue #(.WIDTH(QW), .DEPTH(2)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wdata   ({f_tick, f_info}),
    .q_full  (q_full),
    .rd      (q_pop),
    .rdata   (q_rdata),
    .q_empty (q_empty)
  );

  assign b_tick = q_rdata[QW-1 -: TICK_BITS];
  assign b_info = q_rdata[$bits(sync_info_t)-1:0];

  bcst_back #(.TICK_BITS(TICK_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .freq         (freq),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .q_tick       (b_tick),
    .q_info       (b_info),
    .empty        (empty),
    .pop          (pop),
    .timestamp_ms (timestamp_ms),
    .unix_seconds (unix_seconds),
    .offset_ms    (offset_ms),
    .status       (status)
  );

endmodule
